FILE: rtl/fec_pkg.sv
// shared constants and payload types of the elevator controller
`timescale 1ns / 1ps
`default_nettype none

package fec_pkg;

  localparam int MAX_RIDERS  = 10;
  localparam int FLOOR_COUNT = 16;
  localparam int CALL_DEPTH  = 2 * MAX_RIDERS;
  localparam int FLOOR_W     = 4;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_TICK    = 1'b1
  } fec_cmd_e;

  typedef struct packed {
    fec_cmd_e           command;
    logic [FLOOR_W-1:0] from_floor;
    logic [FLOOR_W-1:0] to_floor;
  } fec_in_t;

  typedef struct packed {
    logic               accepted;
    logic [FLOOR_W-1:0] car_floor;
    logic               going_up;
    logic               moved;
    logic               rider_left;
    logic               idle;
  } fec_out_t;

endpackage

`default_nettype wire

FILE: rtl/fifo_elevator_controller.sv
// Single-car elevator controller, first come first served. Each item gives
// one result. A rider request that leaves room for two calls scans the rider
// slots one per cycle for a free one, then appends pickup and destination to
// the call list; with no room or no free slot it is refused. A tick reads the
// oldest call, moves the car, then walks the call list one entry a cycle to
// find and close up the first call at the new floor, and scans the rider
// slots one per cycle to unload one rider. A tick on an empty list goes
// straight to its result.
// The call list lives in a one-write, one-read memory with a registered read
// port, and that single port sets the pace of the walk.
// The input stalls while an item is being worked on; a finished result sits
// in the output register and the next item is taken meanwhile. An output
// stall holds a later item in its last cycle until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module fifo_elevator_controller import fec_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire fec_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output fec_out_t      out_data_o
);

  localparam int CIW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int CCW = $clog2(CALL_DEPTH + 1);
  localparam int SW  = CCW + 1;
  localparam int RIW = (MAX_RIDERS > 1) ? $clog2(MAX_RIDERS) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSCAN,
    S_RAPP2,
    S_TGT,
    S_SCAN,
    S_SHIFT,
    S_UNLOAD,
    S_EMIT
  } state_e;

  state_e                  state_q, state_d;
  logic [FLOOR_W-1:0]      floor_q, floor_d;
  logic                    dir_q, dir_d;
  logic [CCW-1:0]          call_cnt_q, call_cnt_d;
  logic [MAX_RIDERS-1:0]   rider_valid_q, rider_valid_d;
  logic [CIW-1:0]          idx_q, idx_d;
  logic [RIW-1:0]          r_idx_q, r_idx_d;
  logic [FLOOR_W-1:0]      from_q, from_d;
  logic [FLOOR_W-1:0]      to_q, to_d;
  logic                    acc_q, acc_d;
  logic                    moved_q, moved_d;
  logic                    left_q, left_d;
  logic                    out_valid_q, out_valid_d;
  fec_out_t                out_q, out_d;

  // call list memory and rider destinations
  logic [FLOOR_W-1:0]      call_mem [CALL_DEPTH];
  logic [FLOOR_W-1:0]      rider_dest [MAX_RIDERS];
  logic [FLOOR_W-1:0]      rd_q;
  logic [CIW-1:0]          rd_addr;
  logic                    mem_we;
  logic [CIW-1:0]          mem_waddr;
  logic [FLOOR_W-1:0]      mem_wdata;
  logic                    dest_we;

  logic [SW-1:0]           idx_p1, idx_p2, cnt_x;

  assign idx_p1 = SW'(idx_q) + SW'(1);
  assign idx_p2 = SW'(idx_q) + SW'(2);
  assign cnt_x  = SW'(call_cnt_q);

  always_ff @(posedge clk_i) begin
    rd_q <= call_mem[rd_addr];
    if (mem_we) begin
      call_mem[mem_waddr] <= mem_wdata;
    end
    if (dest_we) begin
      rider_dest[r_idx_q] <= to_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    floor_d       = floor_q;
    dir_d         = dir_q;
    call_cnt_d    = call_cnt_q;
    rider_valid_d = rider_valid_q;
    idx_d         = idx_q;
    r_idx_d       = r_idx_q;
    from_d        = from_q;
    to_d          = to_q;
    acc_d         = acc_q;
    moved_d       = moved_q;
    left_d        = left_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    rd_addr       = '0;
    mem_we        = 1'b0;
    mem_waddr     = call_cnt_q[CIW-1:0];
    mem_wdata     = from_q;
    dest_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          from_d  = in_data_i.from_floor;
          to_d    = in_data_i.to_floor;
          acc_d   = 1'b0;
          moved_d = 1'b0;
          left_d  = 1'b0;
          r_idx_d = '0;
          if (in_data_i.command == CMD_REQUEST) begin
            if ((cnt_x + SW'(2) <= SW'(CALL_DEPTH)) &&
                (int'(in_data_i.from_floor) < FLOOR_COUNT) &&
                (int'(in_data_i.to_floor) < FLOOR_COUNT)) begin
              state_d = S_RSCAN;
            end else begin
              state_d = S_EMIT;
            end
          end else if (call_cnt_q == '0) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_TGT;
          end
        end
      end

      S_RSCAN: begin
        if (!rider_valid_q[r_idx_q]) begin
          rider_valid_d[r_idx_q] = 1'b1;
          dest_we    = 1'b1;
          mem_we     = 1'b1;
          call_cnt_d = call_cnt_q + CCW'(1);
          state_d    = S_RAPP2;
        end else if (r_idx_q == RIW'(MAX_RIDERS - 1)) begin
          state_d = S_EMIT;
        end else begin
          r_idx_d = r_idx_q + RIW'(1);
        end
      end

      S_RAPP2: begin
        mem_we     = 1'b1;
        mem_wdata  = to_q;
        call_cnt_d = call_cnt_q + CCW'(1);
        acc_d      = 1'b1;
        state_d    = S_EMIT;
      end

      // rd_q holds the oldest call
      S_TGT: begin
        if (rd_q > floor_q) begin
          dir_d = 1'b1;
          if (int'(floor_q) + 1 < FLOOR_COUNT) begin
            floor_d = floor_q + FLOOR_W'(1);
            moved_d = 1'b1;
          end
        end else if (rd_q < floor_q) begin
          dir_d   = 1'b0;
          floor_d = floor_q - FLOOR_W'(1);
          moved_d = 1'b1;
        end
        idx_d   = '0;
        state_d = S_SCAN;
      end

      // rd_q holds entry idx_q
      S_SCAN: begin
        if (rd_q == floor_q) begin
          if (idx_p1 < cnt_x) begin
            rd_addr = CIW'(idx_p1);
            state_d = S_SHIFT;
          end else begin
            call_cnt_d = call_cnt_q - CCW'(1);
            state_d    = S_UNLOAD;
          end
        end else if (idx_p1 < cnt_x) begin
          rd_addr = CIW'(idx_p1);
          idx_d   = CIW'(idx_p1);
        end else begin
          state_d = S_UNLOAD;
        end
      end

      // close the gap: rd_q holds entry idx_q + 1
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_q;
        idx_d     = CIW'(idx_p1);
        if (idx_p2 < cnt_x) begin
          rd_addr = CIW'(idx_p2);
        end else begin
          call_cnt_d = call_cnt_q - CCW'(1);
          state_d    = S_UNLOAD;
        end
      end

      S_UNLOAD: begin
        if (rider_valid_q[r_idx_q] && (rider_dest[r_idx_q] == floor_q)) begin
          rider_valid_d[r_idx_q] = 1'b0;
          left_d  = 1'b1;
          state_d = S_EMIT;
        end else if (r_idx_q == RIW'(MAX_RIDERS - 1)) begin
          state_d = S_EMIT;
        end else begin
          r_idx_d = r_idx_q + RIW'(1);
        end
      end

      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.accepted   = acc_q;
          out_d.car_floor  = floor_q;
          out_d.going_up   = dir_q;
          out_d.moved      = moved_q;
          out_d.rider_left = left_q;
          out_d.idle       = (call_cnt_q == '0);
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      floor_q       <= '0;
      dir_q         <= 1'b1;
      call_cnt_q    <= '0;
      rider_valid_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      floor_q       <= floor_d;
      dir_q         <= dir_d;
      call_cnt_q    <= call_cnt_d;
      rider_valid_q <= rider_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    r_idx_q <= r_idx_d;
    from_q  <= from_d;
    to_q    <= to_d;
    acc_q   <= acc_d;
    moved_q <= moved_d;
    left_q  <= left_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(call_cnt_q) <= SW'(CALL_DEPTH))
    else $error("call count beyond list depth");

  a_floor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(floor_q) < FLOOR_COUNT)
    else $error("car outside the floor range");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (idx_p1 < cnt_x))
    else $error("shift reads past the end of the call list");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.accepted && (out_data_o.moved || out_data_o.rider_left)))
    else $error("request result carries tick flags");
`endif

endmodule

`default_nettype wire
